@@ design/batch_timestamp_smoother_top_assert.svh @@
// Assertion macros for the batch timestamp smoother.
// Used by batch_timestamp_smoother_top; needs no other file.
`ifndef BATCH_TIMESTAMP_SMOOTHER_TOP_ASSERT_SVH
`define BATCH_TIMESTAMP_SMOOTHER_TOP_ASSERT_SVH

// Same-cycle implication, checked on every edge out of reset
`define BTS_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("bts check failed: same-cycle rule");

// Next-cycle implication, checked on every edge out of reset
`define BTS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("bts check failed: next-cycle rule");

`endif

@@ design/bts_pkg.sv @@
// Shared types and constants for the batch timestamp smoother.
// Used by bts_alu and batch_timestamp_smoother_top; no dependencies.
package bts_pkg;

    localparam int MAX_BATCH_DEF = 64;
    localparam int TIME_W        = 64;
    localparam int PERIOD_W      = 32;
    localparam int COUNT_W       = 7;   // frame_count width
    localparam int FIDX_W        = 6;   // frame_index width
    localparam int STAT_W        = 32;  // running counters
    localparam int SPAN_W        = PERIOD_W + COUNT_W;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SPAN,
        ST_START,
        ST_EMIT
    } bts_state_t;

    // Control word for the shared adder
    typedef struct packed {
        logic sub;   // 1: a - b, 0: a + b
    } bts_alu_ctrl_t;

endpackage

@@ design/batch_timestamp_smoother_top.sv @@
// Batch timestamp smoother, top level.
// Depends on bts_pkg, bts_alu and batch_timestamp_smoother_top_assert.svh.
//
// Usage:
//   Input channel s_*: one beat per batch descriptor (frame count, host time
//   of the last frame, current time). Result channel m_*: one beat per
//   frame, in frame order, last_in_batch set on the final one. A zero frame
//   count gives no result beat; counts above MAX_BATCH act as MAX_BATCH.
//   cfg_wr_en/cfg_wr_data load the nominal frame period; write only while
//   idle.
//   Sequence: a one-frame batch goes from acceptance straight to ST_EMIT;
//   a batch of n > 1 frames first passes ST_SPAN (span multiply) and
//   ST_START (start subtract), then gives one beat per cycle in ST_EMIT
//   while m_ready does not stall it, one pass per frame through the shared
//   64-bit adder; m_valid is driven from the registered output beat.
//   s_ready is high only between batches; the last beat of a batch may
//   still wait in the output register while the next batch is taken.
//   A stall on m_ready holds the output register and pauses the sequencer.
//   Reset (aresetn low, synchronous) clears the period, the counters and
//   the monotonic history; no result beat is pending after reset.
`include "batch_timestamp_smoother_top_assert.svh"

module batch_timestamp_smoother_top
    import bts_pkg::*;
#(
    parameter int MAX_BATCH = MAX_BATCH_DEF
)
(
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 cfg_wr_en,
    input  logic [PERIOD_W-1:0]  cfg_wr_data,

    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [COUNT_W-1:0]   s_frame_count,
    input  logic [TIME_W-1:0]    s_last_frame_time,
    input  logic [TIME_W-1:0]    s_now_time,

    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [TIME_W-1:0]    m_assigned_time,
    output logic [FIDX_W-1:0]    m_frame_index,
    output logic                 m_last_in_batch,
    output logic [STAT_W-1:0]    m_batches_smoothed,
    output logic [STAT_W-1:0]    m_frames_smoothed
);

    bts_state_t          state_reg, state_next;

    logic [PERIOD_W-1:0] period_reg;
    logic [COUNT_W-1:0]  n_reg;
    logic [TIME_W-1:0]   base_reg;
    logic [TIME_W-1:0]   now_reg;
    logic [TIME_W-1:0]   span_reg;
    logic [TIME_W-1:0]   cand_reg;
    logic [FIDX_W-1:0]   idx_reg;
    logic [TIME_W-1:0]   last_assigned_reg;
    logic                have_last_reg;
    logic [STAT_W-1:0]   batch_cnt_reg;
    logic [STAT_W-1:0]   frame_cnt_reg;

    logic                m_valid_reg;
    logic [TIME_W-1:0]   out_time_reg;
    logic [FIDX_W-1:0]   out_idx_reg;
    logic                out_last_reg;
    logic [STAT_W-1:0]   out_batches_reg;
    logic [STAT_W-1:0]   out_frames_reg;

    logic                accept;
    logic                emit;
    logic                out_free;
    logic                at_final;
    logic [COUNT_W-1:0]  n_in;
    logic [COUNT_W-1:0]  n_m1;
    logic [SPAN_W-1:0]   span_prod;
    logic [TIME_W-1:0]   start_val;
    logic [TIME_W-1:0]   t_sel;
    logic [TIME_W-1:0]   t_clamped;

    bts_alu_ctrl_t       alu_ctrl;
    logic [TIME_W-1:0]   alu_a;
    logic [TIME_W-1:0]   alu_b;
    logic [TIME_W-1:0]   alu_res;
    logic                alu_carry;

    // Frame count limited to the largest batch
    assign n_in = (s_frame_count > COUNT_W'(MAX_BATCH)) ? COUNT_W'(MAX_BATCH)
                                                        : s_frame_count;

    assign accept     = s_valid && s_ready && (s_frame_count != '0);
    assign out_free   = !m_valid_reg || m_ready;
    assign at_final   = ({1'b0, idx_reg} == (n_reg - COUNT_W'(1)));
    assign n_m1       = n_reg - COUNT_W'(1);

    // Span multiply: 32 x 7 bits, registered in ST_SPAN
    assign span_prod = SPAN_W'(period_reg) * SPAN_W'(n_m1);

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = (n_in == COUNT_W'(1)) ? ST_EMIT : ST_SPAN;
                end
            end
            ST_SPAN:  state_next = ST_START;
            ST_START: state_next = ST_EMIT;
            ST_EMIT: begin
                if (emit && at_final) begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs and shared adder operand select
    always_comb begin
        s_ready      = 1'b0;
        emit         = 1'b0;
        alu_ctrl.sub = 1'b0;
        alu_a        = cand_reg;
        alu_b        = TIME_W'(period_reg);
        case (state_reg)
            ST_IDLE:  s_ready = 1'b1;
            ST_SPAN:  ;
            ST_START: begin
                alu_ctrl.sub = 1'b1;
                alu_a        = base_reg;
                alu_b        = span_reg;
            end
            ST_EMIT:  emit = out_free;
            default:  ;
        endcase
    end

    bts_alu u_alu (
        .ctrl   (alu_ctrl),
        .op_a   (alu_a),
        .op_b   (alu_b),
        .result (alu_res),
        .carry  (alu_carry)
    );

    // Start time: base - span when base > span, else 1
    assign start_val = (alu_carry && (alu_res != '0)) ? alu_res : TIME_W'(1);

    // Monotonic clamp of the current candidate
    assign t_sel     = (cand_reg == '0) ? now_reg : cand_reg;
    assign t_clamped = (have_last_reg && (t_sel <= last_assigned_reg))
                       ? (last_assigned_reg + TIME_W'(1)) : t_sel;

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            period_reg    <= '0;
            have_last_reg <= 1'b0;
            last_assigned_reg <= '0;
            batch_cnt_reg <= '0;
            frame_cnt_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                period_reg <= cfg_wr_data;
            end
            if (accept && (n_in != COUNT_W'(1))) begin
                batch_cnt_reg <= batch_cnt_reg + STAT_W'(1);
                frame_cnt_reg <= frame_cnt_reg + STAT_W'(n_in);
            end
            if (emit) begin
                last_assigned_reg <= t_clamped;
                have_last_reg     <= 1'b1;
                m_valid_reg       <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Batch working registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            n_reg    <= n_in;
            now_reg  <= s_now_time;
            base_reg <= (s_last_frame_time == '0) ? s_now_time : s_last_frame_time;
            cand_reg <= s_last_frame_time;
            idx_reg  <= '0;
        end
        if (state_reg == ST_SPAN) begin
            span_reg <= TIME_W'(span_prod);
        end
        if (state_reg == ST_START) begin
            cand_reg <= start_val;
        end
        if (emit) begin
            cand_reg <= alu_res;
            idx_reg  <= idx_reg + FIDX_W'(1);
        end
    end

    // Output register, one result beat
    always_ff @(posedge aclk) begin
        if (emit) begin
            out_time_reg    <= t_clamped;
            out_idx_reg     <= idx_reg;
            out_last_reg    <= at_final;
            out_batches_reg <= batch_cnt_reg;
            out_frames_reg  <= frame_cnt_reg;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_assigned_time    = out_time_reg;
    assign m_frame_index      = out_idx_reg;
    assign m_last_in_batch    = out_last_reg;
    assign m_batches_smoothed = out_batches_reg;
    assign m_frames_smoothed  = out_frames_reg;

    // Checks
    `BTS_ASSERT_NOW(a_out_matches_history, aclk, aresetn,
        m_valid_reg, have_last_reg && (last_assigned_reg == out_time_reg))
    `BTS_ASSERT_NOW(a_idx_in_batch, aclk, aresetn,
        state_reg == ST_EMIT, ({1'b0, idx_reg} < n_reg))
    `BTS_ASSERT_NEXT(a_batch_count_step, aclk, aresetn,
        accept && (n_in != COUNT_W'(1)),
        batch_cnt_reg == $past(batch_cnt_reg) + STAT_W'(1))

endmodule

@@ design/bts_alu.sv @@
// Shared 64-bit add/subtract unit of the batch timestamp smoother.
// Depends on bts_pkg for widths and the control struct.
module bts_alu
    import bts_pkg::*;
(
    input  bts_alu_ctrl_t       ctrl,
    input  logic [TIME_W-1:0]   op_a,
    input  logic [TIME_W-1:0]   op_b,
    output logic [TIME_W-1:0]   result,
    output logic                carry
);

    logic [TIME_W-1:0] b_eff;
    logic [TIME_W:0]   full_sum;

    // Subtract as a + ~b + 1; carry out set means a >= b
    assign b_eff    = ctrl.sub ? ~op_b : op_b;
    assign full_sum = {1'b0, op_a} + {1'b0, b_eff} + {{TIME_W{1'b0}}, ctrl.sub};
    assign result   = full_sum[TIME_W-1:0];
    assign carry    = full_sum[TIME_W];

endmodule
